/* hdl/hv_output_supervisor_defines.svh */
// Assertion macros shared by the supervisor RTL.
`ifndef HV_OUTPUT_SUPERVISOR_DEFINES_SVH
`define HV_OUTPUT_SUPERVISOR_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset
`define HVS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hvs check failed");

// Next-cycle implication, checked on every clock edge out of reset
`define HVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hvs check failed");

`endif

/* hdl/hvs_pkg.sv */
`default_nettype none

package hvs_pkg;

    // Tick ages saturate at 2^17 - 1
    localparam int AGE_W = 17;
    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam int VOLT_W = 16;
    localparam int FRAC_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Default timing parameters
    localparam int DEBOUNCE_MS_DEF = 50;
    localparam int MEAS_PERIOD_MS_DEF = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLTAGE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLTAGE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_BAND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_TIME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_COOL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FRACTION  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_MAX       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_CANCEL    = 3'd7;

    // Register reset values
    localparam logic [VOLT_W-1:0] STABLE_BAND_RST  = 16'd20;
    localparam logic [VOLT_W-1:0] STABLE_TIME_RST  = 16'd1000;
    localparam logic [VOLT_W-1:0] CHANGE_COOL_RST  = 16'd500;
    localparam logic [FRAC_W-1:0] LOW_FRACTION_RST = 8'd128;
    localparam logic [VOLT_W-1:0] LOW_MAX_RST      = 16'd10000;
    localparam logic [VOLT_W-1:0] LOW_CANCEL_RST   = 16'd1000;

    typedef struct packed {
        logic [VOLT_W-1:0] max_voltage;
        logic [VOLT_W-1:0] min_voltage;
        logic [VOLT_W-1:0] stable_band;
        logic [VOLT_W-1:0] stable_time_ms;
        logic [VOLT_W-1:0] change_cooldown_ms;
        logic [FRAC_W-1:0] low_fraction_q8;
        logic [VOLT_W-1:0] low_max_ms;
        logic [VOLT_W-1:0] low_cancel_ms;
    } cfg_t;

    typedef struct packed {
        logic              switch_level;
        logic [VOLT_W-1:0] target_request;
        logic [VOLT_W-1:0] measured_volts;
    } item_t;

    typedef struct packed {
        logic              enable_state;
        logic [VOLT_W-1:0] setpoint_volts;
        logic [VOLT_W-1:0] applied_target;
        logic              measure_tick;
        logic              stable_flag;
        logic              drop_event;
        logic              drop_latched;
        logic              shutdown_event;
        logic [AGE_W-1:0]  low_duration_ms;
    } result_t;

    // Saturating age increment
    function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
        age_inc = (a == AGE_MAX) ? AGE_MAX : a + 1'b1;
    endfunction

endpackage

`default_nettype wire

/* hdl/hvs_cfg_regs.sv */
`default_nettype none

module hvs_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [hvs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hvs_pkg::CFG_DATA_W-1:0] cfg_data,
    output hvs_pkg::cfg_t                       cfg
);
    import hvs_pkg::*;

    cfg_t cfg_reg;

    // Register file with reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_voltage        <= '0;
            cfg_reg.min_voltage        <= '0;
            cfg_reg.stable_band        <= STABLE_BAND_RST;
            cfg_reg.stable_time_ms     <= STABLE_TIME_RST;
            cfg_reg.change_cooldown_ms <= CHANGE_COOL_RST;
            cfg_reg.low_fraction_q8    <= LOW_FRACTION_RST;
            cfg_reg.low_max_ms         <= LOW_MAX_RST;
            cfg_reg.low_cancel_ms      <= LOW_CANCEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_VOLTAGE:  cfg_reg.max_voltage        <= cfg_data;
                REG_MIN_VOLTAGE:  cfg_reg.min_voltage        <= cfg_data;
                REG_STABLE_BAND:  cfg_reg.stable_band        <= cfg_data;
                REG_STABLE_TIME:  cfg_reg.stable_time_ms     <= cfg_data;
                REG_CHANGE_COOL:  cfg_reg.change_cooldown_ms <= cfg_data;
                REG_LOW_FRACTION: cfg_reg.low_fraction_q8    <= cfg_data[FRAC_W-1:0];
                REG_LOW_MAX:      cfg_reg.low_max_ms         <= cfg_data;
                REG_LOW_CANCEL:   cfg_reg.low_cancel_ms      <= cfg_data;
                default:          cfg_reg.max_voltage        <= cfg_reg.max_voltage;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hdl/hvs_tick_logic.sv */
`default_nettype none

module hvs_tick_logic #(
    parameter int DEBOUNCE_MS    = hvs_pkg::DEBOUNCE_MS_DEF,
    parameter int MEAS_PERIOD_MS = hvs_pkg::MEAS_PERIOD_MS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hvs_pkg::cfg_t   cfg,
    input  wire hvs_pkg::item_t  item_in,
    input  wire logic            advance,
    output hvs_pkg::result_t     res_next
);
    import hvs_pkg::*;

    localparam logic [AGE_W-1:0] DEB_LIMIT  = AGE_W'(DEBOUNCE_MS);
    localparam logic [AGE_W-1:0] MEAS_LIMIT = AGE_W'(MEAS_PERIOD_MS);

    // Supervisor state
    logic              enable_reg, enable_next;
    logic              deb_run_reg, deb_run_next;
    logic [AGE_W-1:0]  deb_age_reg, deb_age_next;
    logic [VOLT_W-1:0] target_reg, target_next;
    logic [AGE_W-1:0]  meas_age_reg, meas_age_next;
    logic [AGE_W-1:0]  off_age_reg, off_age_next;
    logic [AGE_W-1:0]  since_age_reg, since_age_next;
    logic              stable_reg, stable_next;
    logic              drop_reg, drop_next;
    logic [VOLT_W-1:0] prev_volts_reg, prev_volts_next;
    logic              prev_valid_reg, prev_valid_next;
    logic              low_run_reg, low_run_next;
    logic [AGE_W-1:0]  low_age_reg, low_age_next;
    logic              ok_run_reg, ok_run_next;
    logic [AGE_W-1:0]  ok_age_reg, ok_age_next;
    logic [AGE_W-1:0]  low_dur_reg, low_dur_next;

    // One tick of the supervisor
    always_comb
    begin
        logic [VOLT_W-1:0] clamped;
        logic [VOLT_W-1:0] setpoint;
        logic [VOLT_W-1:0] diff;
        logic [VOLT_W:0]   meas_plus_band;
        logic [23:0]       meas_scaled;
        logic [23:0]       sp_scaled;
        logic              mtick;
        logic              drop_ev;
        logic              shut_ev;

        // ages advance
        deb_age_next   = age_inc(deb_age_reg);
        meas_age_next  = age_inc(meas_age_reg);
        off_age_next   = age_inc(off_age_reg);
        since_age_next = age_inc(since_age_reg);
        low_age_next   = age_inc(low_age_reg);
        ok_age_next    = age_inc(ok_age_reg);

        enable_next     = enable_reg;
        deb_run_next    = deb_run_reg;
        target_next     = target_reg;
        stable_next     = stable_reg;
        drop_next       = drop_reg;
        prev_volts_next = prev_volts_reg;
        prev_valid_next = prev_valid_reg;
        low_run_next    = low_run_reg;
        ok_run_next     = ok_run_reg;
        low_dur_next    = low_dur_reg;
        mtick           = 1'b0;
        drop_ev         = 1'b0;
        shut_ev         = 1'b0;

        // clamp and apply the requested target
        clamped = (item_in.target_request > cfg.max_voltage) ?
                  cfg.max_voltage : item_in.target_request;
        if (clamped != '0 && clamped < cfg.min_voltage)
        begin
            clamped = '0;
        end
        if (clamped != target_reg)
        begin
            target_next     = clamped;
            stable_next     = 1'b0;
            drop_next       = 1'b0;
            prev_valid_next = 1'b0;
            since_age_next  = '0;
            off_age_next    = '0;
        end

        // switch debounce
        if (item_in.switch_level != enable_reg)
        begin
            if (!deb_run_reg)
            begin
                deb_run_next = 1'b1;
                deb_age_next = '0;
            end
            else if (deb_age_next > DEB_LIMIT)
            begin
                enable_next  = item_in.switch_level;
                deb_run_next = 1'b0;
            end
        end
        else
        begin
            deb_run_next = 1'b0;
        end

        setpoint = enable_next ? target_next : '0;

        diff = (item_in.measured_volts > setpoint) ?
               item_in.measured_volts - setpoint : setpoint - item_in.measured_volts;
        meas_plus_band = {1'b0, item_in.measured_volts} + {1'b0, cfg.stable_band};
        meas_scaled    = {item_in.measured_volts, 8'd0};
        sp_scaled      = setpoint * cfg.low_fraction_q8;

        // measurement evaluation
        if (meas_age_next >= MEAS_LIMIT)
        begin
            meas_age_next = '0;
            mtick         = 1'b1;

            if (diff > cfg.stable_band)
            begin
                if (stable_next && item_in.measured_volts < setpoint && enable_next)
                begin
                    drop_next = 1'b1;
                    drop_ev   = 1'b1;
                end
                off_age_next = '0;
            end

            stable_next = (setpoint != '0) &&
                          (off_age_next > {1'b0, cfg.stable_time_ms});

            // drop during the rise
            if (!stable_next && !drop_next &&
                since_age_next > {1'b0, cfg.change_cooldown_ms})
            begin
                if ({1'b0, setpoint} > meas_plus_band && prev_valid_next &&
                    {1'b0, prev_volts_reg} > meas_plus_band)
                begin
                    drop_next = 1'b1;
                    drop_ev   = 1'b1;
                end
                prev_volts_next = item_in.measured_volts;
                prev_valid_next = 1'b1;
            end

            // long short-circuit protection
            if (meas_scaled < sp_scaled)
            begin
                ok_run_next = 1'b0;
                if (!low_run_reg)
                begin
                    low_run_next = 1'b1;
                    low_age_next = '0;
                    low_dur_next = '0;
                end
                else
                begin
                    low_dur_next = low_age_next;
                    if (low_age_next > {1'b0, cfg.low_max_ms})
                    begin
                        low_run_next = 1'b0;
                        shut_ev      = 1'b1;
                        if (target_next != '0)
                        begin
                            target_next     = '0;
                            stable_next     = 1'b0;
                            drop_next       = 1'b0;
                            prev_valid_next = 1'b0;
                            since_age_next  = '0;
                            off_age_next    = '0;
                        end
                    end
                end
            end
            else
            begin
                if (!ok_run_reg)
                begin
                    ok_run_next = 1'b1;
                    ok_age_next = '0;
                end
                if (ok_age_next > {1'b0, cfg.low_cancel_ms})
                begin
                    low_run_next = 1'b0;
                    low_dur_next = '0;
                end
            end
        end

        res_next.enable_state    = enable_next;
        res_next.setpoint_volts  = setpoint;
        res_next.applied_target  = target_next;
        res_next.measure_tick    = mtick;
        res_next.stable_flag     = stable_next;
        res_next.drop_event      = drop_ev;
        res_next.drop_latched    = drop_next;
        res_next.shutdown_event  = shut_ev;
        res_next.low_duration_ms = low_dur_next;
    end

    // State update, once per processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            deb_run_reg    <= 1'b0;
            deb_age_reg    <= '0;
            target_reg     <= '0;
            meas_age_reg   <= '0;
            off_age_reg    <= '0;
            since_age_reg  <= '0;
            stable_reg     <= 1'b0;
            drop_reg       <= 1'b0;
            prev_volts_reg <= '0;
            prev_valid_reg <= 1'b0;
            low_run_reg    <= 1'b0;
            low_age_reg    <= '0;
            ok_run_reg     <= 1'b0;
            ok_age_reg     <= '0;
            low_dur_reg    <= '0;
        end
        else if (advance)
        begin
            enable_reg     <= enable_next;
            deb_run_reg    <= deb_run_next;
            deb_age_reg    <= deb_age_next;
            target_reg     <= target_next;
            meas_age_reg   <= meas_age_next;
            off_age_reg    <= off_age_next;
            since_age_reg  <= since_age_next;
            stable_reg     <= stable_next;
            drop_reg       <= drop_next;
            prev_volts_reg <= prev_volts_next;
            prev_valid_reg <= prev_valid_next;
            low_run_reg    <= low_run_next;
            low_age_reg    <= low_age_next;
            ok_run_reg     <= ok_run_next;
            ok_age_reg     <= ok_age_next;
            low_dur_reg    <= low_dur_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/hv_output_supervisor.sv */
// Path: a word accepted into the input register is evaluated there and its
// result is registered in the result register when the word advances.
// Throughput: one word per cycle while result_stall is low; the input
// and result registers let the input take a word while a result waits.
// Reset: rst_n clears all state, empties both registers and loads the
// configuration registers with their defaults.
`default_nettype none

`include "hv_output_supervisor_defines.svh"

module hv_output_supervisor #(
    parameter int DEBOUNCE_MS    = hvs_pkg::DEBOUNCE_MS_DEF,
    parameter int MEAS_PERIOD_MS = hvs_pkg::MEAS_PERIOD_MS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [hvs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hvs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire hvs_pkg::item_t                 item,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output hvs_pkg::result_t                    result
);
    import hvs_pkg::*;

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_valid_reg, in_valid_next;
    result_t res_reg;
    result_t res_next;
    logic    res_valid_reg, res_valid_next;
    logic    advance;
    logic    accept;

    hvs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hvs_tick_logic #(
        .DEBOUNCE_MS    (DEBOUNCE_MS),
        .MEAS_PERIOD_MS (MEAS_PERIOD_MS)
    ) u_tick (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .item_in  (in_reg),
        .advance  (advance),
        .res_next (res_next)
    );

    // Handshake: move the held word whenever the result slot frees up
    assign advance    = in_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    `HVS_ASSERT_NEXT(a_advance_fills, advance, result_valid)
    `HVS_ASSERT_NOW(a_stall_needs_word, item_stall, in_valid_reg && res_valid_reg)
    `HVS_ASSERT_NOW(a_shutdown_zeroes, result_valid && result.shutdown_event, result.measure_tick && (result.applied_target == '0))
    // a trip in the same tick clears the drop latch along with the target
    `HVS_ASSERT_NOW(a_drop_on_meas, result_valid && result.drop_event, result.measure_tick && (result.drop_latched || result.shutdown_event))

endmodule

`default_nettype wire
